// ===== rtl/i2cmbe_pkg.sv =====
`timescale 1ns / 1ps
package i2cmbe_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned BIT_CNT_W     = 4;
    localparam int unsigned PHASE_W       = 16;
    localparam int unsigned POLL_W        = 8;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned CFG_ADDR_W    = 1;

    localparam logic [PHASE_W-1:0]   PHASE_TICKS_RST = 16'd100;
    localparam logic [POLL_W-1:0]    POLL_LIMIT_RST  = 8'd10;
    localparam logic [BIT_CNT_W-1:0] BYTE_BITS       = 4'(BITS_PER_BYTE);

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PHASE_TICKS    = 1'b0,
        CFG_ACK_POLL_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE     = 4'd0,
        S_ST_SETUP = 4'd1,
        S_ST_HOLD  = 4'd2,
        S_SP_SETUP = 4'd3,
        S_SP_RISE  = 4'd4,
        S_SP_FREE  = 4'd5,
        S_WR_LOW   = 4'd6,
        S_WR_HIGH  = 4'd7,
        S_WA_LOW   = 4'd8,
        S_WA_HIGH  = 4'd9,
        S_RD_LOW   = 4'd10,
        S_RD_HIGH  = 4'd11,
        S_RA_LOW   = 4'd12,
        S_RA_HIGH  = 4'd13
    } t_ctrl_state;

    typedef struct packed {
        logic                 scl_level;
        logic                 sda_pull_low;
        logic                 busy_res;
        logic                 done_res;
        logic [7:0]           rx_byte;
        logic                 ack_missing;
    } t_result;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_ticks;
        logic [POLL_W-1:0]  ack_poll_limit;
    } t_cfg;

endpackage

// ===== rtl/i2cmbe_core.sv =====
`timescale 1ns / 1ps
module i2cmbe_core
    import i2cmbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_cfg       i_cfg,
    input  logic [2:0] i_op,
    input  logic [7:0] i_tx_byte,
    input  logic       i_nack_after_read,
    input  logic       i_sda_in,
    output t_result    o_result
);

    t_ctrl_state          r_state, n_state;
    logic [BIT_CNT_W-1:0] r_bit_count, n_bit_count;
    logic [7:0]           r_shift, n_shift;
    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic [POLL_W-1:0]    r_poll, n_poll;
    logic                 r_scl, n_scl;
    logic                 r_sda, n_sda;
    logic                 r_nack, n_nack;
    logic                 r_ack_flag, n_ack_flag;
    logic [7:0]           r_rx, n_rx;
    logic                 done;

    logic [PHASE_W-1:0]   limit;
    logic [POLL_W-1:0]    plim;
    logic                 phase_end;
    logic [BIT_CNT_W-1:0] bit_inc;
    logic [POLL_W-1:0]    poll_inc;
    logic                 byte_end;
    logic                 poll_out;
    t_op                  op;

    assign op        = t_op'(i_op);
    assign limit     = (i_cfg.phase_ticks == '0) ? PHASE_W'(1) : i_cfg.phase_ticks;
    assign plim      = (i_cfg.ack_poll_limit == '0) ? POLL_W'(1) : i_cfg.ack_poll_limit;
    assign phase_end = ({1'b0, r_phase} + (PHASE_W+1)'(1)) >= {1'b0, limit};
    assign bit_inc   = r_bit_count + BIT_CNT_W'(1);
    assign poll_inc  = r_poll + POLL_W'(1);
    assign byte_end  = bit_inc >= BYTE_BITS;
    assign poll_out  = poll_inc >= plim;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                unique case (op)
                    OP_START: n_state = S_ST_SETUP;
                    OP_STOP:  n_state = S_SP_SETUP;
                    OP_WRITE: n_state = S_WR_LOW;
                    OP_READ:  n_state = S_RD_LOW;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_ST_SETUP: if (phase_end) n_state = S_ST_HOLD;
            S_ST_HOLD:  if (phase_end) n_state = S_IDLE;
            S_SP_SETUP: if (phase_end) n_state = S_SP_RISE;
            S_SP_RISE:  if (phase_end) n_state = S_SP_FREE;
            S_SP_FREE:  if (phase_end) n_state = S_IDLE;
            S_WR_LOW:   if (phase_end) n_state = S_WR_HIGH;
            S_WR_HIGH:  if (phase_end) n_state = byte_end ? S_WA_LOW : S_WR_LOW;
            S_WA_LOW:   if (phase_end) n_state = S_WA_HIGH;
            S_WA_HIGH: begin
                if (phase_end) begin
                    if (!i_sda_in) begin
                        n_state = S_IDLE;
                    end else if (poll_out) begin
                        n_state = S_SP_SETUP;
                    end else begin
                        n_state = S_WA_HIGH;
                    end
                end
            end
            S_RD_LOW:   if (phase_end) n_state = S_RD_HIGH;
            S_RD_HIGH:  if (phase_end) n_state = byte_end ? S_RA_LOW : S_RD_LOW;
            S_RA_LOW:   if (phase_end) n_state = S_RA_HIGH;
            S_RA_HIGH:  if (phase_end) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // line levels, datapath and done
    always_comb begin
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_phase     = r_phase;
        n_poll      = r_poll;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_nack      = r_nack;
        n_ack_flag  = r_ack_flag;
        n_rx        = r_rx;
        done        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                unique case (op)
                    OP_START: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b0;
                        n_phase = '0;
                    end
                    OP_STOP: begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b1;
                        n_phase = '0;
                    end
                    OP_WRITE: begin
                        n_shift     = i_tx_byte;
                        n_bit_count = '0;
                        n_ack_flag  = 1'b0;
                        n_scl       = 1'b0;
                        n_sda       = ~i_tx_byte[7];
                        n_phase     = '0;
                    end
                    OP_READ: begin
                        n_shift     = '0;
                        n_bit_count = '0;
                        n_nack      = i_nack_after_read;
                        n_scl       = 1'b0;
                        n_sda       = 1'b0;
                        n_phase     = '0;
                    end
                    default: ;
                endcase
            end
            S_ST_SETUP, S_ST_HOLD, S_SP_SETUP, S_SP_RISE, S_SP_FREE,
            S_WR_LOW, S_WR_HIGH, S_WA_LOW, S_WA_HIGH,
            S_RD_LOW, S_RD_HIGH, S_RA_LOW, S_RA_HIGH: begin
                if (!phase_end) begin
                    n_phase = r_phase + PHASE_W'(1);
                end else begin
                    n_phase = '0;
                    unique case (r_state)
                        S_ST_SETUP: begin
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                        S_ST_HOLD: begin
                            n_scl = 1'b0;
                            n_sda = 1'b1;
                            done  = 1'b1;
                        end
                        S_SP_SETUP: begin
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                        S_SP_RISE: begin
                            n_scl = 1'b1;
                            n_sda = 1'b0;
                        end
                        S_SP_FREE: begin
                            n_scl = 1'b1;
                            n_sda = 1'b0;
                            done  = 1'b1;
                        end
                        S_WR_LOW: begin
                            n_scl = 1'b1;
                        end
                        S_WR_HIGH: begin
                            n_shift     = {r_shift[6:0], 1'b0};
                            n_bit_count = bit_inc;
                            n_scl       = 1'b0;
                            if (byte_end) begin
                                n_poll = '0;
                                n_sda  = 1'b0;
                            end else begin
                                n_sda = ~r_shift[6];
                            end
                        end
                        S_WA_LOW: begin
                            n_scl = 1'b1;
                            n_sda = 1'b0;
                        end
                        S_WA_HIGH: begin
                            if (!i_sda_in) begin
                                n_ack_flag = 1'b0;
                                n_scl      = 1'b0;
                                n_sda      = 1'b1;
                                done       = 1'b1;
                            end else begin
                                n_poll = poll_inc;
                                if (poll_out) begin
                                    n_ack_flag = 1'b1;
                                    n_scl      = 1'b0;
                                    n_sda      = 1'b1;
                                end else begin
                                    n_scl = 1'b1;
                                    n_sda = 1'b0;
                                end
                            end
                        end
                        S_RD_LOW: begin
                            n_scl = 1'b1;
                            n_sda = 1'b0;
                        end
                        S_RD_HIGH: begin
                            n_shift     = {r_shift[6:0], i_sda_in};
                            n_bit_count = bit_inc;
                            n_scl       = 1'b0;
                            n_sda       = byte_end ? ~r_nack : 1'b0;
                        end
                        S_RA_LOW: begin
                            n_scl = 1'b1;
                        end
                        default: begin
                            n_rx  = r_shift;
                            n_scl = 1'b0;
                            n_sda = 1'b0;
                            done  = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_phase = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_phase     <= '0;
            r_poll      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b0;
            r_nack      <= 1'b0;
            r_ack_flag  <= 1'b0;
            r_rx        <= '0;
        end else if (i_fire) begin
            r_state     <= n_state;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_phase     <= n_phase;
            r_poll      <= n_poll;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_nack      <= n_nack;
            r_ack_flag  <= n_ack_flag;
            r_rx        <= n_rx;
        end
    end

    // result of this tick, values after the update
    always_comb begin
        o_result.scl_level    = n_scl;
        o_result.sda_pull_low = n_sda;
        o_result.busy_res     = (n_state != S_IDLE);
        o_result.done_res     = done;
        o_result.rx_byte      = n_rx;
        o_result.ack_missing  = n_ack_flag;
    end

endmodule

// ===== rtl/i2cmbe_out_queue.sv =====
`timescale 1ns / 1ps
module i2cmbe_out_queue
    import i2cmbe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/i2c_master_byte_engine_unit.sv =====
`timescale 1ns / 1ps
// result path: an accepted input beat's result is computed combinationally and registered in the output queue
// throughput: one input beat per cycle while the output queue has space; the pin-timing
// state registers update on each accepted beat; a two-entry output queue keeps input open while
// one result beat waits, and input stalls while both entries are full
// reset: synchronous active-low; state idle, scl released, registers to defaults
module i2c_master_byte_engine_unit
    import i2cmbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_op,
    input  logic [7:0]            i_tx_byte,
    input  logic                  i_nack_after_read,
    input  logic                  i_sda_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_scl_level,
    output logic                  o_sda_pull_low,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [7:0]            o_rx_byte,
    output logic                  o_ack_missing
);

    t_cfg    r_cfg;
    t_result core_result;
    t_result out_result;
    logic    fire;

    assign fire = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks    <= PHASE_TICKS_RST;
            r_cfg.ack_poll_limit <= POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PHASE_TICKS:    r_cfg.phase_ticks    <= i_cfg_data;
                CFG_ACK_POLL_LIMIT: r_cfg.ack_poll_limit <= i_cfg_data[POLL_W-1:0];
                default: ;
            endcase
        end
    end

    i2cmbe_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_cfg             (r_cfg),
        .i_op              (i_op),
        .i_tx_byte         (i_tx_byte),
        .i_nack_after_read (i_nack_after_read),
        .i_sda_in          (i_sda_in),
        .o_result          (core_result)
    );

    i2cmbe_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (core_result),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_result)
    );

    assign o_scl_level    = out_result.scl_level;
    assign o_sda_pull_low = out_result.sda_pull_low;
    assign o_busy_res     = out_result.busy_res;
    assign o_done_res     = out_result.done_res;
    assign o_rx_byte      = out_result.rx_byte;
    assign o_ack_missing  = out_result.ack_missing;

endmodule

// ===== sim/i2c_line_checker.sv =====
`timescale 1ns / 1ps
module i2c_line_checker
    import i2cmbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [2:0]            i_op,
    input  logic [7:0]            i_tx_byte,
    input  logic                  i_nack_after_read,
    input  logic                  i_sda_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_scl_level,
    input  logic                  i_sda_pull_low,
    input  logic                  i_busy_res,
    input  logic                  i_done_res,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_ack_missing,
    output int                    o_fail_count,
    output int                    o_pending,
    output logic                  o_line_busy
);

    t_ctrl_state          st;
    logic [BIT_CNT_W-1:0] nbits;
    logic [7:0]           shifter;
    logic [PHASE_W-1:0]   tick_cnt;
    logic [POLL_W-1:0]    npoll;
    logic                 scl_q;
    logic                 pull_q;
    logic                 nack_q;
    logic                 miss_q;
    logic [7:0]           rx_q;
    logic [PHASE_W-1:0]   cfg_ticks;
    logic [POLL_W-1:0]    cfg_polls;

    t_result pin_q[$];
    int      errs;

    function automatic void move(input t_ctrl_state s, input logic scl, input logic pull);
        st       = s;
        scl_q    = scl;
        pull_q   = pull;
        tick_cnt = '0;
    endfunction

    function automatic void clear_line();
        st        = S_IDLE;
        nbits     = '0;
        shifter   = '0;
        tick_cnt  = '0;
        npoll     = '0;
        scl_q     = 1'b1;
        pull_q    = 1'b0;
        nack_q    = 1'b0;
        miss_q    = 1'b0;
        rx_q      = '0;
        cfg_ticks = PHASE_TICKS_RST;
        cfg_polls = POLL_LIMIT_RST;
    endfunction

    // one clock tick of the pin timing machine
    function automatic t_result advance_tick(input logic [2:0] op, input logic [7:0] tx,
                                             input logic nack, input logic sda);
        t_result     r;
        int unsigned lim;
        int unsigned plim;
        int unsigned cur;
        logic        done;
        lim  = (cfg_ticks == '0) ? 1 : 32'(cfg_ticks);
        plim = (cfg_polls == '0) ? 1 : 32'(cfg_polls);
        cur  = 32'(tick_cnt);
        done = 1'b0;
        if (st == S_IDLE) begin
            case (op)
                OP_START: move(S_ST_SETUP, 1'b1, 1'b0);
                OP_STOP:  move(S_SP_SETUP, 1'b0, 1'b1);
                OP_WRITE: begin
                    shifter = tx;
                    nbits   = '0;
                    miss_q  = 1'b0;
                    move(S_WR_LOW, 1'b0, ~tx[7]);
                end
                OP_READ: begin
                    shifter = '0;
                    nbits   = '0;
                    nack_q  = nack;
                    move(S_RD_LOW, 1'b0, 1'b0);
                end
                default: ;
            endcase
        end else if (cur + 1 < lim) begin
            tick_cnt = tick_cnt + 1'b1;
        end else begin
            case (st)
                S_ST_SETUP: move(S_ST_HOLD, 1'b1, 1'b1);
                S_ST_HOLD: begin
                    move(S_IDLE, 1'b0, 1'b1);
                    done = 1'b1;
                end
                S_SP_SETUP: move(S_SP_RISE, 1'b1, 1'b1);
                S_SP_RISE:  move(S_SP_FREE, 1'b1, 1'b0);
                S_SP_FREE: begin
                    move(S_IDLE, 1'b1, 1'b0);
                    done = 1'b1;
                end
                S_WR_LOW: move(S_WR_HIGH, 1'b1, pull_q);
                S_WR_HIGH: begin
                    shifter = {shifter[6:0], 1'b0};
                    nbits   = nbits + 1'b1;
                    if (nbits >= BYTE_BITS) begin
                        npoll = '0;
                        move(S_WA_LOW, 1'b0, 1'b0);
                    end else begin
                        move(S_WR_LOW, 1'b0, ~shifter[7]);
                    end
                end
                S_WA_LOW: move(S_WA_HIGH, 1'b1, 1'b0);
                S_WA_HIGH: begin
                    if (!sda) begin
                        miss_q = 1'b0;
                        move(S_IDLE, 1'b0, 1'b1);
                        done = 1'b1;
                    end else begin
                        npoll = npoll + 1'b1;
                        if (32'(npoll) >= plim) begin
                            miss_q = 1'b1;
                            move(S_SP_SETUP, 1'b0, 1'b1);
                        end else begin
                            move(S_WA_HIGH, 1'b1, 1'b0);
                        end
                    end
                end
                S_RD_LOW: move(S_RD_HIGH, 1'b1, 1'b0);
                S_RD_HIGH: begin
                    shifter = {shifter[6:0], sda};
                    nbits   = nbits + 1'b1;
                    if (nbits >= BYTE_BITS) begin
                        move(S_RA_LOW, 1'b0, ~nack_q);
                    end else begin
                        move(S_RD_LOW, 1'b0, 1'b0);
                    end
                end
                S_RA_LOW: move(S_RA_HIGH, 1'b1, pull_q);
                S_RA_HIGH: begin
                    rx_q = shifter;
                    move(S_IDLE, 1'b0, 1'b0);
                    done = 1'b1;
                end
                default: begin
                    st       = S_IDLE;
                    tick_cnt = '0;
                end
            endcase
        end
        r.scl_level    = scl_q;
        r.sda_pull_low = pull_q;
        r.busy_res     = (st != S_IDLE);
        r.done_res     = done;
        r.rx_byte      = rx_q;
        r.ack_missing  = miss_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        logic    bad;
        if (!i_rst_n) begin
            clear_line();
            pin_q.delete();
            errs = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                pin_q.push_back(advance_tick(i_op, i_tx_byte, i_nack_after_read, i_sda_in));
            end
            if (i_out_valid && i_out_ready) begin
                seen.scl_level    = i_scl_level;
                seen.sda_pull_low = i_sda_pull_low;
                seen.busy_res     = i_busy_res;
                seen.done_res     = i_done_res;
                seen.rx_byte      = i_rx_byte;
                seen.ack_missing  = i_ack_missing;
                if (pin_q.size() == 0) begin
                    errs = errs + 1;
                    if (errs <= 10) begin
                        $display("%0t unexpected beat scl=%b sda=%b busy=%b done=%b rx=%h miss=%b",
                                 $realtime, seen.scl_level, seen.sda_pull_low, seen.busy_res,
                                 seen.done_res, seen.rx_byte, seen.ack_missing);
                    end
                end else begin
                    want = pin_q.pop_front();
                    bad  = (seen.scl_level !== want.scl_level)
                        || (seen.sda_pull_low !== want.sda_pull_low)
                        || (seen.busy_res !== want.busy_res)
                        || (seen.done_res !== want.done_res)
                        || (seen.rx_byte !== want.rx_byte)
                        || (seen.ack_missing !== want.ack_missing);
                    if (bad) begin
                        errs = errs + 1;
                        if (errs <= 10) begin
                            $display("%0t mismatch exp scl=%b sda=%b busy=%b done=%b rx=%h miss=%b",
                                     $realtime, want.scl_level, want.sda_pull_low,
                                     want.busy_res, want.done_res, want.rx_byte,
                                     want.ack_missing);
                            $display("%0t          got scl=%b sda=%b busy=%b done=%b rx=%h miss=%b",
                                     $realtime, seen.scl_level, seen.sda_pull_low,
                                     seen.busy_res, seen.done_res, seen.rx_byte,
                                     seen.ack_missing);
                        end
                    end
                end
            end
            // register writes land after this edge's tick
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_PHASE_TICKS:    cfg_ticks = i_cfg_data[PHASE_W-1:0];
                    CFG_ACK_POLL_LIMIT: cfg_polls = i_cfg_data[POLL_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count = errs;
        o_pending    = pin_q.size();
        o_line_busy  = (st != S_IDLE);
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import i2cmbe_pkg::*;

    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;
    localparam int         ITEM_GOAL  = 1550;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [2:0]            i_op;
    logic [7:0]            i_tx_byte;
    logic                  i_nack_after_read;
    logic                  i_sda_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_scl_level;
    logic                  o_sda_pull_low;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic [7:0]            o_rx_byte;
    logic                  o_ack_missing;

    int   fail_count;
    int   pending;
    logic line_busy;

    bit   quiet;
    int   calm_left;
    int   items_done;
    int   next_cfg;

    i2c_master_byte_engine_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_tx_byte         (i_tx_byte),
        .i_nack_after_read (i_nack_after_read),
        .i_sda_in          (i_sda_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_scl_level       (o_scl_level),
        .o_sda_pull_low    (o_sda_pull_low),
        .o_busy_res        (o_busy_res),
        .o_done_res        (o_done_res),
        .o_rx_byte         (o_rx_byte),
        .o_ack_missing     (o_ack_missing)
    );

    i2c_line_checker chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_tx_byte         (i_tx_byte),
        .i_nack_after_read (i_nack_after_read),
        .i_sda_in          (i_sda_in),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_scl_level       (o_scl_level),
        .i_sda_pull_low    (o_sda_pull_low),
        .i_busy_res        (o_busy_res),
        .i_done_res        (o_done_res),
        .i_rx_byte         (o_rx_byte),
        .i_ack_missing     (o_ack_missing),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_line_busy       (line_busy)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #16_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // receiver stalls
    initial begin
        int hold;
        hold        = 0;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                i_out_ready <= 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold = hold - 1;
            end else if (i_out_ready) begin
                i_out_ready <= 1'b0;
                hold = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                    : $urandom_range(3, 29);
            end else begin
                i_out_ready <= 1'b1;
                hold = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 7)
                                                    : $urandom_range(20, 200);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        if (calm_left > 0) begin
            calm_left = calm_left - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm_left = $urandom_range(50, 300);
            return 0;
        end
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic sda_draw(input int low_pct);
        return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
    endfunction

    // commands issued mid-transfer are dropped by the engine
    function automatic logic [2:0] noise_op();
        if ($urandom_range(0, 99) < 90) return OP_NONE;
        return 3'($urandom_range(OP_NONE, OP_RSVD_HI));
    endfunction

    task automatic send_beat(input logic [2:0] op, input logic [7:0] tx, input logic nack,
                             input logic sda);
        int   gap;
        logic was_busy;
        was_busy = line_busy;
        gap      = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_op              <= op;
        i_tx_byte         <= tx;
        i_nack_after_read <= nack;
        i_sda_in          <= sda;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (was_busy || (op >= OP_START && op <= OP_READ)) items_done = items_done + 1;
    endtask

    task automatic finish_cmd(input int low_pct);
        while (line_busy) begin
            send_beat(noise_op(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      sda_draw(low_pct));
        end
    endtask

    task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic nack,
                           input int low_pct);
        send_beat(op, tx, nack, sda_draw(low_pct));
        finish_cmd(low_pct);
    endtask

    task automatic idle_noise(input int n);
        repeat (n) begin
            send_beat($urandom_range(0, 1) ? OP_NONE
                                           : 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [PHASE_W-1:0] ticks, input logic [POLL_W-1:0] polls);
        settle();
        write_cfg(CFG_PHASE_TICKS, ticks);
        write_cfg(CFG_ACK_POLL_LIMIT, {8'($urandom_range(0, 255)), polls});
    endtask

    task automatic random_cfg();
        logic [PHASE_W-1:0] ticks;
        logic [POLL_W-1:0]  polls;
        int                 r;
        r = $urandom_range(0, 9);
        ticks = PHASE_W'((r < 5) ? 1 : (r < 7) ? 2 : (r < 8) ? 0 : $urandom_range(3, 6));
        r = $urandom_range(0, 19);
        polls = POLL_W'((r < 5) ? 1 : (r < 9) ? 2 : (r < 11) ? 0 : (r < 12) ? 255
              : $urandom_range(3, 12));
        configure(ticks, polls);
    endtask

    function automatic int pick_ack_odds();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 100;
        if (r < 7) return 95;
        if (r < 8) return 60;
        if (r < 9) return 10;
        return 0;
    endfunction

    // start, address, a few data bytes, stop
    task automatic bus_transfer();
        int odds;
        int n;
        odds = pick_ack_odds();
        n    = $urandom_range(1, 4);
        run_cmd(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), odds);
        run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), odds);
        if ($urandom_range(0, 1)) begin
            repeat (n) run_cmd(OP_WRITE, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), odds);
        end else begin
            for (int k = 0; k < n; k++) begin
                run_cmd(OP_READ, 8'($urandom_range(0, 255)), (k == n - 1) ? 1'b1 : 1'b0, 50);
            end
        end
        run_cmd(OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 50);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_addr        = '0;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_op              = OP_NONE;
        i_tx_byte         = '0;
        i_nack_after_read = 1'b0;
        i_sda_in          = 1'b1;
        quiet             = 1'b0;
        calm_left         = 0;
        items_done        = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset timing
        run_cmd(OP_START, 8'h00, 1'b0, 50);

        configure(1, 3);
        run_cmd(OP_START, 8'hFF, 1'b1, 50);
        run_cmd(OP_WRITE, 8'hFF, 1'b0, 100);
        run_cmd(OP_WRITE, 8'h00, 1'b1, 100);
        run_cmd(OP_WRITE, 8'hA5, 1'b0, 0);
        run_cmd(OP_READ, 8'h00, 1'b0, 0);
        run_cmd(OP_READ, 8'hFF, 1'b1, 100);
        run_cmd(OP_READ, 8'($urandom_range(0, 255)), 1'b1, 50);
        send_beat(OP_WRITE, 8'h3C, 1'b0, 1'b1);
        send_beat(OP_START, 8'hC3, 1'b1, 1'b0);
        send_beat(OP_READ, 8'h5A, 1'b1, 1'b1);
        finish_cmd(30);
        run_cmd(OP_STOP, 8'h00, 1'b0, 50);
        for (logic [2:0] op = OP_RSVD_LO; op <= OP_RSVD_HI && op >= OP_RSVD_LO; op++) begin
            send_beat(op, 8'hFF, 1'b1, 1'b0);
        end

        configure(0, 0);
        run_cmd(OP_WRITE, 8'h5A, 1'b0, 0);
        run_cmd(OP_READ, 8'h96, 1'b0, 50);
        run_cmd(OP_START, 8'h00, 1'b0, 50);
        run_cmd(OP_STOP, 8'h00, 1'b0, 50);

        configure(1, 255);
        run_cmd(OP_WRITE, 8'h81, 1'b0, 0);

        configure(16'd64, 1);
        quiet = 1'b1;
        run_cmd(OP_STOP, 8'h00, 1'b0, 50);
        quiet = 1'b0;

        random_cfg();
        next_cfg = items_done + 250;
        while (items_done < ITEM_GOAL) begin
            if (items_done >= next_cfg) begin
                random_cfg();
                next_cfg = items_done + $urandom_range(150, 350);
            end
            if ($urandom_range(0, 99) < 85) begin
                bus_transfer();
            end else if ($urandom_range(0, 1)) begin
                run_cmd(3'($urandom_range(OP_START, OP_READ)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), pick_ack_odds());
            end else begin
                idle_noise($urandom_range(1, 5));
            end
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_core.sv
rtl/i2cmbe_out_queue.sv
rtl/i2c_master_byte_engine_unit.sv
sim/i2c_line_checker.sv
sim/tb_top.sv
